### hw/rtl/assert_macros.svh
// Assertion helpers for the SRTP receive tracker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define SRTP_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("srtp assertion failed");

`define SRTP_ASSERT_RST(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("srtp reset assertion failed");

`else

`define SRTP_ASSERT(lbl, clk, rst_n, prop)

`define SRTP_ASSERT_RST(lbl, clk, prop)

`endif

`endif

### hw/rtl/srtp_rrw_pkg.sv
package srtp_rrw_pkg;

	localparam int unsigned SEQ_W       = 16;
	localparam int unsigned ROC_W       = 32;
	localparam int unsigned INDEX_W     = ROC_W + SEQ_W;
	localparam int unsigned STATUS_W    = 3;
	localparam int unsigned WIN_LEN_DEF = 64;
	localparam int unsigned WIN_LEN_MAX = 64;

	localparam logic [SEQ_W-1:0] HALF_RANGE = 16'h8000;

	localparam logic [STATUS_W-1:0] ST_ESTIMATE  = 3'd0;
	localparam logic [STATUS_W-1:0] ST_ADVANCED  = 3'd1;
	localparam logic [STATUS_W-1:0] ST_LATE      = 3'd2;
	localparam logic [STATUS_W-1:0] ST_TOO_OLD   = 3'd3;
	localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd4;

	typedef struct packed {
		logic             func;
		logic [SEQ_W-1:0] seq;
		logic             restart;
	} pkt_t;

	typedef struct packed {
		logic [ROC_W-1:0]    roc;
		logic [INDEX_W-1:0]  packet_index;
		logic                accepted;
		logic [STATUS_W-1:0] status;
	} res_t;

endpackage

### hw/rtl/srtp_roc_and_replay_window.sv
// SRTP receive tracker: one packet transaction in, one result transaction out, one packet per
// clock sustained. A packet waits in an input register, where the rollover counter estimate
// and the replay window check and update are done in a single pass against the tracking
// state, and the result lands in an output register. The result is valid in the cycle after
// the packet leaves the input register, which it does once the output register is free or
// being emptied. The input stalls only while both registers are full and the result is not
// being taken. The state update of one packet is visible to the next packet in the following
// cycle, so back-to-back packets see each other in order. Estimates (func 0) keep the window
// and ROC and set the highest sequence only from a first packet; commits (func 1) should only be
// sent for packets that passed authentication. restart clears all tracking before the packet.
`include "assert_macros.svh"

module srtp_roc_and_replay_window import srtp_rrw_pkg::*; #(
	parameter int unsigned WIN_LEN = WIN_LEN_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic pkt_valid,
	output logic pkt_ready,
	input  pkt_t pkt,
	output logic res_valid,
	input  logic res_ready,
	output res_t res
);

	logic valid_s1;
	pkt_t item_s1;
	logic res_valid_q;
	res_t res_q;
	res_t res_nxt;
	logic fire;

	assign fire      = valid_s1 && (!res_valid_q || res_ready);
	assign pkt_ready = !valid_s1 || fire;
	assign res_valid = res_valid_q;
	assign res       = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pkt_ready) begin
			valid_s1 <= pkt_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pkt_ready && pkt_valid) begin
			item_s1 <= pkt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (fire) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_q <= res_nxt;
		end
	end

	srtp_rrw_core #(
		.WIN_LEN(WIN_LEN)
	) u_core (
		.clk   (clk),
		.arst_n(arst_n),
		.fire  (fire),
		.item  (item_s1),
		.res   (res_nxt)
	);

	`SRTP_ASSERT(a_fire_gives_result, clk, arst_n, fire |=> res_valid)
	`SRTP_ASSERT(a_stall_only_when_full, clk, arst_n,
		!pkt_ready |-> (valid_s1 && res_valid_q && !res_ready))
	`SRTP_ASSERT(a_result_held, clk, arst_n,
		(res_valid && !res_ready) |=> (res_valid && $stable(res)))
	`SRTP_ASSERT_RST(a_idle_in_reset, clk, !arst_n |-> (!res_valid && pkt_ready))

endmodule

### hw/rtl/srtp_rrw_core.sv
`include "assert_macros.svh"

module srtp_rrw_core import srtp_rrw_pkg::*; #(
	parameter int unsigned WIN_LEN = WIN_LEN_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic fire,
	input  pkt_t item,
	output res_t res
);

	localparam int unsigned IDX_W = $clog2(WIN_LEN);

	logic [SEQ_W-1:0]   hs_q;
	logic [ROC_W-1:0]   roc_q;
	logic               seen_q;
	logic [WIN_LEN-1:0] bits_q;

	logic [SEQ_W-1:0]   hs_eff;
	logic [ROC_W-1:0]   roc_base;
	logic [WIN_LEN-1:0] bits_eff;
	logic [SEQ_W-1:0]   d;
	logic [SEQ_W-1:0]   age;
	logic [IDX_W-1:0]   idx;
	logic [ROC_W-1:0]   r;
	logic               advance;
	logic               too_old;
	logic               dup;
	logic [WIN_LEN-1:0] bits_adv;
	logic [WIN_LEN-1:0] bits_nxt;

	always_comb begin
		hs_eff   = (item.restart || !seen_q) ? item.seq : hs_q;
		roc_base = item.restart ? '0 : roc_q;
		bits_eff = item.restart ? '0 : bits_q;
		d        = item.seq - hs_eff;
		age      = hs_eff - item.seq;
		idx      = age[IDX_W-1:0];

		if (d < HALF_RANGE) begin
			r = roc_base + ROC_W'(item.seq < hs_eff);
		end else begin
			r = roc_base - ROC_W'(item.seq > hs_eff);
		end

		advance = (d != '0) && (d < HALF_RANGE);
		too_old = age >= SEQ_W'(WIN_LEN);
		dup     = !too_old && bits_eff[idx];

		if (d >= SEQ_W'(WIN_LEN)) begin
			bits_adv = WIN_LEN'(1);
		end else begin
			bits_adv = (bits_eff << d[IDX_W-1:0]) | WIN_LEN'(1);
		end

		bits_nxt         = bits_eff;
		res.roc          = r;
		res.packet_index = {r, item.seq};
		res.accepted     = 1'b1;
		res.status       = ST_ESTIMATE;
		if (item.func) begin
			if (advance) begin
				bits_nxt   = bits_adv;
				res.status = ST_ADVANCED;
			end else if (too_old) begin
				res.accepted = 1'b0;
				res.status   = ST_TOO_OLD;
			end else if (dup) begin
				res.accepted = 1'b0;
				res.status   = ST_DUPLICATE;
			end else begin
				bits_nxt   = bits_eff | (WIN_LEN'(1) << idx);
				res.status = ST_LATE;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hs_q   <= '0;
			roc_q  <= '0;
			seen_q <= 1'b0;
			bits_q <= '0;
		end else if (fire) begin
			seen_q <= 1'b1;
			bits_q <= bits_nxt;
			if (item.func && advance) begin
				hs_q  <= item.seq;
				roc_q <= r;
			end else begin
				hs_q  <= hs_eff;
				roc_q <= roc_base;
			end
		end
	end

	`SRTP_ASSERT(a_seen_after_fire, clk, arst_n, fire |=> seen_q)
	`SRTP_ASSERT(a_adv_takes_seq, clk, arst_n,
		(fire && res.status == ST_ADVANCED) |=> (hs_q == $past(item.seq) && bits_q[0]))
	`SRTP_ASSERT(a_reject_keeps_window, clk, arst_n,
		(fire && !res.accepted) |=> (bits_q == $past(bits_eff)))
	`SRTP_ASSERT(a_estimate_keeps_roc, clk, arst_n,
		(fire && !item.func) |=> (roc_q == $past(roc_base)))

endmodule

### verif/tb_srtp_roc_and_replay_window.sv
`timescale 1ns / 1ps

module tb_srtp_roc_and_replay_window import srtp_rrw_pkg::*;;

	localparam logic FN_ESTIMATE = 1'b0;
	localparam logic FN_COMMIT   = 1'b1;
	localparam int   WINDOW      = WIN_LEN_DEF;
	localparam int   STALL_LIMIT = 4000;
	localparam int   SHOWN_MAX   = 10;

	logic clk       = 1'b0;
	logic arst_n    = 1'b1;
	logic pkt_valid = 1'b0;
	logic res_ready = 1'b0;
	pkt_t pkt       = '0;
	logic pkt_ready;
	logic res_valid;
	res_t res;

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int mismatch_count = 0;
	res_t expected_results[$];

	// tracker state as the block should hold it
	logic [SEQ_W-1:0] trk_highest = '0;
	logic [ROC_W-1:0] trk_roc     = '0;
	logic             trk_seen    = 1'b0;
	logic [63:0]      trk_window  = '0;

	srtp_roc_and_replay_window i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.pkt_valid (pkt_valid),
		.pkt_ready (pkt_ready),
		.pkt       (pkt),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		res_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	function automatic res_t predict_result(input pkt_t p);
		logic [SEQ_W-1:0] d;
		logic [ROC_W-1:0] r;
		int               age;
		res_t             o;
		if (p.restart) begin
			trk_highest = '0;
			trk_roc     = '0;
			trk_seen    = 1'b0;
			trk_window  = '0;
		end
		if (!trk_seen) begin
			trk_highest = p.seq;
			trk_seen    = 1'b1;
		end
		d = p.seq - trk_highest;
		r = trk_roc;
		if (d < HALF_RANGE) begin
			if (p.seq < trk_highest)
				r = r + 1;
		end else if (p.seq > trk_highest) begin
			r = r - 1;
		end
		o.accepted = 1'b1;
		o.status   = ST_ESTIMATE;
		if (p.func == FN_COMMIT) begin
			if (d != 0 && d < HALF_RANGE) begin
				if (d >= WINDOW)
					trk_window = '0;
				else
					trk_window = trk_window << d;
				trk_window[0] = 1'b1;
				trk_highest   = p.seq;
				trk_roc       = r;
				o.status      = ST_ADVANCED;
			end else begin
				age = (d == 0) ? 0 : 65536 - int'(d);
				if (age >= WINDOW) begin
					o.accepted = 1'b0;
					o.status   = ST_TOO_OLD;
				end else if (trk_window[age]) begin
					o.accepted = 1'b0;
					o.status   = ST_DUPLICATE;
				end else begin
					trk_window[age] = 1'b1;
					o.status        = ST_LATE;
				end
			end
		end
		o.roc          = r;
		o.packet_index = {r, p.seq};
		return o;
	endfunction

	task automatic flag_mismatch(input string what, input logic [63:0] want,
		input logic [63:0] got);
		mismatch_count++;
		if (mismatch_count <= SHOWN_MAX)
			$display("mismatch on %s: expected %h, got %h", what, want, got);
	endtask

	always @(posedge clk) begin : check_results
		res_t want;
		if (arst_n && res_valid && res_ready) begin
			if (expected_results.size() == 0) begin
				flag_mismatch("unexpected transaction", '0, 64'(res.packet_index));
			end else begin
				want = expected_results.pop_front();
				if (res.roc !== want.roc)
					flag_mismatch("roc", 64'(want.roc), 64'(res.roc));
				if (res.packet_index !== want.packet_index)
					flag_mismatch("packet_index", 64'(want.packet_index),
						64'(res.packet_index));
				if (res.accepted !== want.accepted)
					flag_mismatch("accepted", 64'(want.accepted), 64'(res.accepted));
				if (res.status !== want.status)
					flag_mismatch("status", 64'(want.status), 64'(res.status));
			end
		end
	end

	task automatic send_packet(input logic func, input logic [SEQ_W-1:0] seq,
		input logic restart);
		pkt_t p;
		res_t exp_res;
		p.func    = func;
		p.seq     = seq;
		p.restart = restart;
		while ($urandom_range(99) < send_idle_pct) begin
			pkt_valid <= 1'b0;
			@(posedge clk);
		end
		pkt       <= p;
		pkt_valid <= 1'b1;
		do
			@(posedge clk);
		while (!pkt_ready);
		exp_res = predict_result(p);
		expected_results = {expected_results, exp_res};
	endtask

	task automatic wait_drained();
		while (expected_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_latch_and_extremes();
		send_packet(FN_ESTIMATE, 16'hffff, 1'b1);
		send_packet(FN_ESTIMATE, 16'h0000, 1'b0);
		send_packet(FN_COMMIT,   16'h0000, 1'b0);
		send_packet(FN_COMMIT,   16'hffff, 1'b0);
		send_packet(FN_COMMIT,   16'hffff, 1'b0);
		send_packet(FN_COMMIT,   16'h0000, 1'b0);
		send_packet(FN_COMMIT,   16'hffc1, 1'b0);
		send_packet(FN_COMMIT,   16'hffc0, 1'b0);
		send_packet(FN_COMMIT,   16'h8000, 1'b0);
		send_packet(FN_ESTIMATE, 16'h7fff, 1'b0);
		send_packet(FN_COMMIT,   16'h0040, 1'b0);
		send_packet(FN_COMMIT,   16'h0001, 1'b0);
		send_packet(FN_COMMIT,   16'h0041, 1'b0);
		send_packet(FN_COMMIT,   16'h1234, 1'b1);
		send_packet(FN_COMMIT,   16'h1234, 1'b0);
		send_packet(FN_COMMIT,   16'h8000, 1'b1);
		send_packet(FN_COMMIT,   16'h0000, 1'b0);
		send_packet(FN_COMMIT,   16'hffff, 1'b0);
		send_packet(FN_COMMIT,   16'h0000, 1'b0);
		// restart clears a non-zero ROC, then a late packet wraps ROC below zero
		send_packet(FN_ESTIMATE, 16'h0000, 1'b1);
		send_packet(FN_COMMIT,   16'hffff, 1'b0);
		send_packet(FN_ESTIMATE, 16'hfff0, 1'b0);
		send_packet(FN_COMMIT,   16'h7fff, 1'b0);
	endtask

	// mostly in-order packets around a moving cursor, commits with some estimates, with reordering, repeats and jumps
	task automatic test_reordered_stream(input int n);
		logic [SEQ_W-1:0] cursor;
		logic [SEQ_W-1:0] s;
		logic             rst_flag;
		int               roll;
		cursor = 16'($urandom);
		for (int k = 0; k < n; k++) begin
			rst_flag = (k == 0) || ($urandom_range(99) < 2);
			if (rst_flag)
				cursor = $urandom_range(1) ? 16'(16'hffff - $urandom_range(40))
					: 16'($urandom);
			roll = $urandom_range(99);
			if (roll < 45) begin
				cursor = 16'(cursor + $urandom_range(1, 4));
				s = cursor;
			end else if (roll < 70) begin
				s = 16'(cursor - $urandom_range(0, 70));
			end else if (roll < 77) begin
				s = cursor;
			end else if (roll < 84) begin
				cursor = 16'(cursor + $urandom_range(64, 32768));
				s = cursor;
			end else if (roll < 92) begin
				s = 16'(cursor - $urandom_range(64, 32768));
			end else begin
				s = 16'($urandom);
			end
			send_packet(($urandom_range(99) < 80) ? FN_COMMIT : FN_ESTIMATE, s, rst_flag);
		end
	endtask

	task automatic test_random_noise(input int n);
		for (int k = 0; k < n; k++)
			send_packet(1'($urandom_range(1)), 16'($urandom), $urandom_range(99) < 5);
	endtask

	// sender holds off until every outstanding result is back
	task automatic test_drain_hold();
		test_reordered_stream(10);
		pkt_valid <= 1'b0;
		wait_drained();
		@(posedge clk);
		test_reordered_stream(10);
	endtask

	initial begin : watchdog
		int idle_cycles = 0;
		while (idle_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((pkt_valid && pkt_ready) || (res_valid && res_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		arst_n <= 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 37;
		recv_idle_pct = 76;
		test_latch_and_extremes();
		test_reordered_stream(150);
		test_random_noise(20);

		send_idle_pct = 76;
		recv_idle_pct = 37;
		test_reordered_stream(150);
		test_random_noise(20);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_drain_hold();
		test_reordered_stream(120);

		pkt_valid <= 1'b0;
		wait_drained();
		repeat (8) @(posedge clk);
		if (mismatch_count == 0 && expected_results.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

### srtp_roc_and_replay_window.f
+incdir+hw/rtl
hw/rtl/srtp_rrw_pkg.sv
hw/rtl/srtp_rrw_core.sv
hw/rtl/srtp_roc_and_replay_window.sv
verif/tb_srtp_roc_and_replay_window.sv
